// ===== hw/rtl/mfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message FIFO package
// Shared widths, command and status codes, and the stored entry layout.
// ----------------------------------------------------------------------------
package mfc_pkg;

    // Default queue depth
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int PROC_W   = 8;
    localparam int MSG_W    = 16;
    localparam int ARG_W    = 32;
    localparam int STATUS_W = 2;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_STORE  = 3'd0,
        CMD_POP    = 3'd1,
        CMD_CANCEL = 3'd2,
        CMD_QUERY  = 3'd3,
        CMD_FLUSH  = 3'd4
    } t_cmd;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // One stored message
    typedef struct packed {
        logic [PROC_W-1:0] process_id;
        logic [MSG_W-1:0]  msg_id;
        logic [ARG_W-1:0]  arg_handle;
    } t_entry;

    // One response
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic                deliver;
        logic                free_arg;
        logic [PROC_W-1:0]   out_process;
        logic [MSG_W-1:0]    out_msg;
        logic [ARG_W-1:0]    out_arg;
    } t_result;

endpackage

// ===== hw/rtl/mfc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message FIFO request channel
// Valid/ready channel carrying one command and its operands.
// ----------------------------------------------------------------------------
interface mfc_req_if
    import mfc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [PROC_W-1:0] process_id;
    logic [MSG_W-1:0]  msg_id;
    logic [ARG_W-1:0]  arg_handle;

    modport source (output valid, command, process_id, msg_id, arg_handle, input ready);
    modport sink   (input valid, command, process_id, msg_id, arg_handle, output ready);
endinterface

// ===== hw/rtl/mfc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message FIFO response channel
// Valid/ready channel carrying one response per command.
// ----------------------------------------------------------------------------
interface mfc_rsp_if
    import mfc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic                deliver;
    logic                free_arg;
    logic [PROC_W-1:0]   out_process;
    logic [MSG_W-1:0]    out_msg;
    logic [ARG_W-1:0]    out_arg;

    modport source (output valid, status, found, deliver, free_arg, out_process, out_msg,
                    out_arg, input ready);
    modport sink   (input valid, status, found, deliver, free_arg, out_process, out_msg,
                    out_arg, output ready);
endinterface

// ===== hw/rtl/mfc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message FIFO entry RAM
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module mfc_ram
    import mfc_pkg::*;
#(
    parameter int  QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int IDX_W       = $clog2(QUEUE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_entry           i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data
);

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/message_fifo_with_cancel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message FIFO with cancel
// Bounded queue of messages with store, pop, cancel, query and flush commands.
//
// Usage:
//   i_req carries one command per transfer; o_rsp returns exactly one
//   response per command, in command order. Commands are handled one at a
//   time: i_req.ready is high only while the controller is idle.
//   Entries live in a RAM with one read port and registered read data.
//   Store, failed pop and unused codes go from idle straight to the output
//   state; a pop first reads the head entry (S_POP); cancel, query and
//   flush first scan every stored entry (S_SCAN). The scan reads each
//   stored entry once; cancel and flush write a matching entry back with
//   its message id cleared in the cycle after its read. With the receiver
//   ready, the next command transfers on the same edge as the response.
//   While the receiver stalls, the next command is still taken and
//   processed; its response waits for the output register to free up and
//   i_req stays stalled until then.
//   Synchronous reset empties the queue (head, tail and count to zero); the
//   RAM is not cleared, as only stored entries are ever read.
// ----------------------------------------------------------------------------
module message_fifo_with_cancel
    import mfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mfc_req_if.sink       i_req,
    mfc_rsp_if.source     o_rsp
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;

    // Scan control
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_left;
    logic             r_rd_pend;
    logic [IDX_W-1:0] r_rd_slot;
    logic             r_hit;

    // Latched command operands
    t_cmd              r_cmd;
    logic [PROC_W-1:0] r_proc;
    logic [MSG_W-1:0]  r_msg;

    // Pending and output responses
    t_result r_res;
    t_result r_out;
    logic    r_out_valid;

    // RAM ports
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    t_entry           w_wr_data;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    t_entry           w_rd_data;

    logic    w_accept;
    logic    w_full;
    logic    w_empty;
    logic    w_proc_match;
    logic    w_msg_match;
    logic    w_modify;
    logic    w_hit;
    logic    w_scan_done;
    t_cmd    w_in_cmd;
    t_result w_res_init;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Handshake and queue status
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_in_cmd    = t_cmd'(i_req.command);
    assign w_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty     = (r_count == '0);

    // Response seed at request time: full store and empty pop report status
    always_comb begin
        w_res_init = '0;
        if ((w_in_cmd == CMD_STORE) && w_full) begin
            w_res_init.status = ST_FULL;
        end
        if ((w_in_cmd == CMD_POP) && w_empty) begin
            w_res_init.status = ST_EMPTY;
        end
    end

    // Compare of the entry read back during a scan
    assign w_proc_match = (w_rd_data.process_id == r_proc);
    assign w_msg_match  = (w_rd_data.msg_id == r_msg);
    assign w_modify     = w_proc_match
                       && ((r_cmd == CMD_FLUSH) || ((r_cmd == CMD_CANCEL) && w_msg_match));
    assign w_hit        = w_proc_match && w_msg_match && (r_cmd == CMD_QUERY);
    assign w_scan_done  = (r_left == '0) && !r_rd_pend;

    // RAM port muxing: stores and pop reads at request time, scan reads and
    // write-backs while scanning
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_tail;
        w_wr_data = '{process_id: i_req.process_id, msg_id: i_req.msg_id,
                      arg_handle: i_req.arg_handle};
        w_rd_en   = 1'b0;
        w_rd_addr = r_idx;
        if (w_accept && (w_in_cmd == CMD_STORE) && !w_full) begin
            w_wr_en = 1'b1;
        end
        if (w_accept && (w_in_cmd == CMD_POP) && !w_empty) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_head;
        end
        if ((r_state == S_SCAN) && (r_left != '0)) begin
            w_rd_en = 1'b1;
        end
        if ((r_state == S_SCAN) && r_rd_pend && w_modify) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_rd_slot;
            w_wr_data = '{process_id: w_rd_data.process_id, msg_id: '0,
                          arg_handle: w_rd_data.arg_handle};
        end
    end

    mfc_ram #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Controller: state, queue pointers and response registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_left      <= '0;
            r_rd_pend   <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output transfer; S_OUT reloads the register itself
            if (r_out_valid && o_rsp.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd  <= w_in_cmd;
                        r_proc <= i_req.process_id;
                        r_msg  <= i_req.msg_id;
                        r_res  <= w_res_init;
                        case (w_in_cmd) inside
                            CMD_STORE: begin
                                if (!w_full) begin
                                    r_tail  <= next_slot(r_tail);
                                    r_count <= r_count + 1'b1;
                                end
                                r_state <= S_OUT;
                            end
                            CMD_POP: begin
                                if (w_empty) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_POP;
                                end
                            end
                            CMD_CANCEL, CMD_QUERY, CMD_FLUSH: begin
                                r_idx     <= r_head;
                                r_left    <= r_count;
                                r_rd_pend <= 1'b0;
                                r_hit     <= 1'b0;
                                r_state   <= S_SCAN;
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_POP: begin
                    r_res.deliver     <= (w_rd_data.process_id != '0)
                                      && (w_rd_data.msg_id != '0);
                    r_res.free_arg    <= (w_rd_data.arg_handle != '0);
                    r_res.out_process <= w_rd_data.process_id;
                    r_res.out_msg     <= w_rd_data.msg_id;
                    r_res.out_arg     <= w_rd_data.arg_handle;
                    r_head            <= next_slot(r_head);
                    r_count           <= r_count - 1'b1;
                    r_state           <= S_OUT;
                end
                S_SCAN: begin
                    // read one entry per cycle, compare it the cycle after
                    r_rd_pend <= (r_left != '0);
                    r_rd_slot <= r_idx;
                    if (r_left != '0) begin
                        r_idx  <= next_slot(r_idx);
                        r_left <= r_left - 1'b1;
                    end
                    if (r_rd_pend && w_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (w_scan_done) begin
                        r_res.found <= (r_cmd == CMD_QUERY) && r_hit;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Response channel
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.found       = r_out.found;
    assign o_rsp.deliver     = r_out.deliver;
    assign o_rsp.free_arg    = r_out.free_arg;
    assign o_rsp.out_process = r_out.out_process;
    assign o_rsp.out_msg     = r_out.out_msg;
    assign o_rsp.out_arg     = r_out.out_arg;

`ifndef ASSERT_OFF
    // Entry count never exceeds the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // Tail is always head plus count, modulo the depth
    a_ptr_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((SUM_W'(r_head) + SUM_W'(r_count)) == SUM_W'(r_tail))
        || ((SUM_W'(r_head) + SUM_W'(r_count)) == (SUM_W'(r_tail) + SUM_W'(QUEUE_DEPTH))))
        else $error("head, tail and count out of step");

    // RAM writes come only from a store transfer or a scan write-back
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> ((r_state == S_IDLE) && w_accept)
                 || ((r_state == S_SCAN) && r_rd_pend))
        else $error("unexpected RAM write");

    // A finished scan enters S_OUT in the next cycle
    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && w_scan_done) |=> (r_state == S_OUT))
        else $error("scan did not complete");
`endif

endmodule
